// ===== sv/pl0_pcode_stack_machine_defines.svh =====
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine: assertion macros
// Assertion macros for the RTL files of the stack machine (used by the controller).
// ----------------------------------------------------------------------------
`ifndef PL0_PCODE_STACK_MACHINE_DEFINES_SVH
`define PL0_PCODE_STACK_MACHINE_DEFINES_SVH

// Assertion checked on the rising clock edge, switched off while reset is low.
`define PL0_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion checked on every rising clock edge, reset included.
`define PL0_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pl0_pkg.sv =====
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine package
// Types, codes and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pl0_pkg;

  localparam int STACK_DEPTH_DEF = 512;
  localparam int MAX_LEVEL_DEF   = 31;
  localparam int CODE_DEPTH      = 256;
  localparam int PC_W            = $clog2(CODE_DEPTH);
  localparam int DATA_W          = 32;

  // Instruction opcodes.
  typedef enum logic [2:0] {
    OP_LIT = 3'd0,
    OP_OPR = 3'd1,
    OP_LOD = 3'd2,
    OP_STO = 3'd3,
    OP_CAL = 3'd4,
    OP_INT = 3'd5,
    OP_JMP = 3'd6,
    OP_JPC = 3'd7
  } opcode_t;

  // OPR subcodes.
  localparam logic [DATA_W-1:0] SUB_RET   = 32'd0;
  localparam logic [DATA_W-1:0] SUB_NEG   = 32'd1;
  localparam logic [DATA_W-1:0] SUB_ADD   = 32'd2;
  localparam logic [DATA_W-1:0] SUB_SUB   = 32'd3;
  localparam logic [DATA_W-1:0] SUB_MUL   = 32'd4;
  localparam logic [DATA_W-1:0] SUB_DIV   = 32'd5;
  localparam logic [DATA_W-1:0] SUB_ODD   = 32'd6;
  localparam logic [DATA_W-1:0] SUB_EQ    = 32'd8;
  localparam logic [DATA_W-1:0] SUB_NE    = 32'd9;
  localparam logic [DATA_W-1:0] SUB_LT    = 32'd10;
  localparam logic [DATA_W-1:0] SUB_GE    = 32'd11;
  localparam logic [DATA_W-1:0] SUB_GT    = 32'd12;
  localparam logic [DATA_W-1:0] SUB_LE    = 32'd13;
  localparam logic [DATA_W-1:0] SUB_WRITE = 32'd14;
  localparam logic [DATA_W-1:0] SUB_NL    = 32'd15;

  // Fault codes.
  typedef enum logic [1:0] {
    FLT_NONE     = 2'd0,
    FLT_DIV_ZERO = 2'd1,
    FLT_STACK    = 2'd2
  } fault_t;

  // Input item.
  typedef struct packed {
    logic [2:0]               opcode;
    logic [4:0]               level;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     halted;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     print_newline;
    logic [1:0]               fault;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CHAIN_RD,
    S_CHAIN_WB,
    S_RD_A,
    S_RD_B,
    S_CAPB,
    S_EXEC,
    S_CAL2,
    S_CAL3,
    S_DIV,
    S_DIV_WB,
    S_DONE
  } ctrl_state_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_PREP,
    CMD_CHAIN_RD,
    CMD_CHAIN_WB,
    CMD_RD_A,
    CMD_RD_B,
    CMD_CAPB,
    CMD_EXEC,
    CMD_CAL2,
    CMD_CAL3,
    CMD_DIV_WB,
    CMD_RESULT
  } dp_cmd_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic clear_last;
    logic chain_done;
    logic need_chain;
    logic need_rd_a;
    logic need_rd_b;
    logic is_cal;
    logic div_start;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/pl0_ram.sv =====
// ----------------------------------------------------------------------------
// PL/0 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pl0_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[ra];
    end
  end

endmodule

// ===== sv/pl0_div.sv =====
// ----------------------------------------------------------------------------
// PL/0 divider
// Signed restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module pl0_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pl0_pkg::DATA_W-1:0]    dividend,
  input  logic [pl0_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [pl0_pkg::DATA_W-1:0]    quotient
);
  import pl0_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] ub_r, ub_nxt;
  logic             neg_r, neg_nxt;
  logic [DATA_W:0]  rem_sh;
  logic [DATA_W:0]  diff;

  // One restoring step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ub_nxt   = ub_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, quo_r[DATA_W-1]};
    diff     = rem_sh - {1'b0, ub_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      ub_nxt   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ub_r  <= ub_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== sv/pl0_dpath.sv =====
// ----------------------------------------------------------------------------
// PL/0 datapath
// Stack memory, pointers, program counter, ALU, divider and result register.
// ----------------------------------------------------------------------------
module pl0_dpath #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LEVEL   = pl0_pkg::MAX_LEVEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pl0_pkg::dp_cmd_t    cmd,
  output pl0_pkg::dp_status_t status,
  input  pl0_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pl0_pkg::out_item_t  out_data
);
  import pl0_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SW = DATA_W + 2;
  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam logic signed [SW-1:0] TOP_ADDR = SW'(STACK_DEPTH - 1);

  // Saturate a signed address into the stack; the top bit flags a clamp.
  function automatic logic [AW:0] fit(input logic signed [SW-1:0] v);
    logic [AW:0] res;
    if (v < 0) begin
      res = {1'b1, {AW{1'b0}}};
    end else if (v > TOP_ADDR) begin
      res = {1'b1, AW'(STACK_DEPTH - 1)};
    end else begin
      res = {1'b0, v[AW-1:0]};
    end
    return res;
  endfunction

  // Registers.
  logic [AW-1:0]     t_r, base_r, b1_r, clr_r;
  logic [PC_W-1:0]   pc_r, p_r;
  opcode_t           op_r;
  logic [4:0]        lvl_r;
  logic [DATA_W-1:0] arg_r, a_r, b_r, pval_r;
  logic [LW-1:0]     hops_r;
  logic              flt_r, divz_r, pv_r, pnl_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Memory port and helpers.
  logic              we, rd_en;
  logic [AW-1:0]     wa, ra;
  logic [DATA_W-1:0] wd, rd_data;
  logic [DATA_W-1:0] alu_res, prod, div_q;
  logic              div_done, div_go, flt_set;
  logic signed [SW-1:0] t_s, base_s, b1_s, arg_s;
  logic [AW:0] f_tp1, f_tp2, f_tp3, f_tm1, f_bm1, f_dst, f_tint, f_lnk, f_a;

  // Instruction decode.
  logic is_opr, s_ret, s_neg, s_odd, s_wr, s_nl, s_bin, s_div;
  assign is_opr = (op_r == OP_OPR);
  assign s_ret  = is_opr && (arg_r == SUB_RET);
  assign s_neg  = is_opr && (arg_r == SUB_NEG);
  assign s_odd  = is_opr && (arg_r == SUB_ODD);
  assign s_wr   = is_opr && (arg_r == SUB_WRITE);
  assign s_nl   = is_opr && (arg_r == SUB_NL);
  assign s_bin  = is_opr && ((arg_r == SUB_ADD) || (arg_r == SUB_SUB) ||
                             (arg_r == SUB_MUL) || (arg_r == SUB_DIV) ||
                             (arg_r == SUB_EQ)  || (arg_r == SUB_NE)  ||
                             (arg_r == SUB_LT)  || (arg_r == SUB_GE)  ||
                             (arg_r == SUB_GT)  || (arg_r == SUB_LE));
  assign s_div  = is_opr && (arg_r == SUB_DIV);

  // Saturated address candidates.
  assign t_s    = $signed({{(SW-AW){1'b0}}, t_r});
  assign base_s = $signed({{(SW-AW){1'b0}}, base_r});
  assign b1_s   = $signed({{(SW-AW){1'b0}}, b1_r});
  assign arg_s  = $signed({{(SW-DATA_W){arg_r[DATA_W-1]}}, arg_r});
  assign f_tp1  = fit(t_s + SW'(1));
  assign f_tp2  = fit(t_s + SW'(2));
  assign f_tp3  = fit(t_s + SW'(3));
  assign f_tm1  = fit(t_s - SW'(1));
  assign f_bm1  = fit(base_s - SW'(1));
  assign f_dst  = fit(b1_s + arg_s);
  assign f_tint = fit(t_s + arg_s);
  assign f_lnk  = fit($signed({{(SW-DATA_W){rd_data[DATA_W-1]}}, rd_data}));
  assign f_a    = fit($signed({{(SW-DATA_W){a_r[DATA_W-1]}}, a_r}));

  // Binary operations on the two popped words.
  assign prod = a_r * b_r;
  always_comb begin
    unique case (arg_r)
      SUB_ADD: alu_res = a_r + b_r;
      SUB_SUB: alu_res = a_r - b_r;
      SUB_MUL: alu_res = prod;
      SUB_EQ:  alu_res = DATA_W'(a_r == b_r);
      SUB_NE:  alu_res = DATA_W'(a_r != b_r);
      SUB_LT:  alu_res = DATA_W'($signed(a_r) <  $signed(b_r));
      SUB_GE:  alu_res = DATA_W'($signed(a_r) >= $signed(b_r));
      SUB_GT:  alu_res = DATA_W'($signed(a_r) >  $signed(b_r));
      SUB_LE:  alu_res = DATA_W'($signed(a_r) <= $signed(b_r));
      default: alu_res = '0;
    endcase
  end

  assign div_go = (cmd == CMD_EXEC) && status.div_start;

  // Memory addressing and stack-range fault detection per command.
  always_comb begin
    rd_en   = 1'b0;
    ra      = t_r;
    we      = 1'b0;
    wa      = t_r;
    wd      = '0;
    flt_set = 1'b0;
    unique case (cmd)
      CMD_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
      end
      CMD_PREP: begin
        if (s_ret) begin
          flt_set = f_bm1[AW];
        end else if (s_bin) begin
          flt_set = f_tm1[AW];
        end
      end
      CMD_CHAIN_RD: begin
        rd_en = 1'b1;
        ra    = b1_r;
      end
      CMD_CHAIN_WB: begin
        flt_set = f_lnk[AW];
      end
      CMD_RD_A: begin
        rd_en = 1'b1;
        if (s_ret) begin
          ra      = f_tp2[AW-1:0];
          flt_set = f_tp2[AW];
        end else if (op_r == OP_LOD || op_r == OP_STO) begin
          ra      = (op_r == OP_LOD) ? f_dst[AW-1:0] : t_r;
          flt_set = (op_r == OP_LOD) && f_dst[AW];
        end
      end
      CMD_RD_B: begin
        if (s_ret) begin
          rd_en   = 1'b1;
          ra      = f_tp3[AW-1:0];
          flt_set = f_tp3[AW];
        end else if (s_bin) begin
          rd_en   = 1'b1;
          ra      = f_tp1[AW-1:0];
          flt_set = f_tp1[AW];
        end
      end
      CMD_EXEC: begin
        unique case (op_r)
          OP_LIT: begin
            we = 1'b1;
            wa = f_tp1[AW-1:0];
            wd = arg_r;
            flt_set = f_tp1[AW];
          end
          OP_OPR: begin
            if (s_ret) begin
              flt_set = f_a[AW];
            end else if (s_neg) begin
              we = 1'b1;
              wd = ~a_r + 1'b1;
            end else if (s_odd) begin
              we = 1'b1;
              wd = {{(DATA_W-1){1'b0}}, a_r[0]};
            end else if (s_wr) begin
              flt_set = f_tm1[AW];
            end else if (s_bin && !status.div_start) begin
              we = 1'b1;
              wd = alu_res;
            end
          end
          OP_LOD: begin
            we = 1'b1;
            wa = f_tp1[AW-1:0];
            wd = a_r;
            flt_set = f_tp1[AW];
          end
          OP_STO: begin
            we = 1'b1;
            wa = f_dst[AW-1:0];
            wd = a_r;
            flt_set = f_dst[AW] | f_tm1[AW];
          end
          OP_CAL: begin
            we = 1'b1;
            wa = f_tp1[AW-1:0];
            wd = DATA_W'(b1_r);
            flt_set = f_tp1[AW];
          end
          OP_INT: flt_set = f_tint[AW];
          OP_JMP: ;
          OP_JPC: flt_set = f_tm1[AW];
          default: ;
        endcase
      end
      CMD_CAL2: begin
        we = 1'b1;
        wa = f_tp2[AW-1:0];
        wd = DATA_W'(base_r);
        flt_set = f_tp2[AW];
      end
      CMD_CAL3: begin
        we = 1'b1;
        wa = f_tp3[AW-1:0];
        wd = DATA_W'(p_r);
        flt_set = f_tp3[AW];
      end
      CMD_DIV_WB: begin
        we = 1'b1;
        wd = div_q;
      end
      default: ;
    endcase
  end

  // Architectural state and result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r         <= '0;
      base_r      <= AW'(1);
      pc_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == CMD_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd == CMD_RESULT) begin
        out_valid_r <= 1'b1;
        pc_r        <= p_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd == CMD_PREP) begin
        if (s_ret) begin
          t_r <= f_bm1[AW-1:0];
        end else if (s_bin) begin
          t_r <= f_tm1[AW-1:0];
        end
      end
      if (cmd == CMD_EXEC) begin
        if (op_r == OP_LIT || op_r == OP_LOD) begin
          t_r <= f_tp1[AW-1:0];
        end else if (op_r == OP_STO || op_r == OP_JPC || s_wr) begin
          t_r <= f_tm1[AW-1:0];
        end else if (op_r == OP_INT) begin
          t_r <= f_tint[AW-1:0];
        end else if (s_ret) begin
          base_r <= f_a[AW-1:0];
        end
      end
      if (cmd == CMD_CAL3) begin
        base_r <= f_tp1[AW-1:0];
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r   <= opcode_t'(in_data.opcode);
      lvl_r  <= in_data.level;
      arg_r  <= in_data.operand;
      flt_r  <= 1'b0;
      divz_r <= 1'b0;
      pv_r   <= 1'b0;
      pval_r <= '0;
      pnl_r  <= 1'b0;
    end else if (flt_set) begin
      flt_r <= 1'b1;
    end
    if (cmd == CMD_PREP) begin
      p_r  <= pc_r + 1'b1;
      b1_r <= base_r;
      if (int'(lvl_r) > MAX_LEVEL) begin
        hops_r <= LW'(MAX_LEVEL);
      end else begin
        hops_r <= LW'(lvl_r);
      end
    end
    if (cmd == CMD_CHAIN_WB) begin
      b1_r   <= f_lnk[AW-1:0];
      hops_r <= hops_r - 1'b1;
    end
    if (cmd == CMD_RD_B) begin
      a_r <= rd_data;
    end
    if (cmd == CMD_CAPB) begin
      b_r <= rd_data;
    end
    if (cmd == CMD_EXEC) begin
      if (s_ret) begin
        p_r <= b_r[PC_W-1:0];
      end else if (s_wr) begin
        pv_r   <= 1'b1;
        pval_r <= a_r;
      end else if (s_nl) begin
        pnl_r <= 1'b1;
      end else if (s_div && (b_r == '0)) begin
        divz_r <= 1'b1;
      end else if (op_r == OP_JMP) begin
        p_r <= arg_r[PC_W-1:0];
      end else if (op_r == OP_JPC && a_r == DATA_W'(lvl_r)) begin
        p_r <= arg_r[PC_W-1:0];
      end
    end
    if (cmd == CMD_CAL3) begin
      p_r <= arg_r[PC_W-1:0];
    end
    if (cmd == CMD_RESULT) begin
      out_data_r.next_pc       <= p_r;
      out_data_r.halted        <= (p_r == '0);
      out_data_r.print_valid   <= pv_r;
      out_data_r.print_value   <= pval_r;
      out_data_r.print_newline <= pnl_r;
      out_data_r.fault         <= flt_r ? FLT_STACK : (divz_r ? FLT_DIV_ZERO : FLT_NONE);
    end
  end

  // Stack memory.
  pl0_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .wa      (wa),
    .wd      (wd),
    .rd_en   (rd_en),
    .ra      (ra),
    .rd_data (rd_data)
  );

  // Iterative divider.
  pl0_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Status toward the controller.
  always_comb begin
    status.clear_last = (clr_r == AW'(STACK_DEPTH - 1));
    status.chain_done = (hops_r == '0);
    status.need_chain = (op_r == OP_LOD) || (op_r == OP_STO) || (op_r == OP_CAL);
    status.need_rd_a  = s_ret || s_neg || s_odd || s_wr || s_bin ||
                        (op_r == OP_LOD) || (op_r == OP_STO) || (op_r == OP_JPC);
    status.need_rd_b  = s_ret || s_bin;
    status.is_cal     = (op_r == OP_CAL);
    status.div_start  = s_div && (b_r != '0);
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/pl0_ctrl.sv =====
// ----------------------------------------------------------------------------
// PL/0 controller
// Sequences the clearing pass and the steps of each instruction.
// ----------------------------------------------------------------------------
`include "pl0_pcode_stack_machine_defines.svh"

module pl0_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pl0_pkg::dp_status_t status,
  output pl0_pkg::dp_cmd_t    cmd
);
  import pl0_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (status.clear_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_PREP;
      S_PREP: begin
        priority if (status.need_chain) state_nxt = S_CHAIN_RD;
        else if (status.need_rd_a)     state_nxt = S_RD_A;
        else                           state_nxt = S_EXEC;
      end
      S_CHAIN_RD: begin
        priority if (!status.chain_done) state_nxt = S_CHAIN_WB;
        else if (status.need_rd_a)      state_nxt = S_RD_A;
        else                            state_nxt = S_EXEC;
      end
      S_CHAIN_WB: state_nxt = S_CHAIN_RD;
      S_RD_A:     state_nxt = S_RD_B;
      S_RD_B:     state_nxt = status.need_rd_b ? S_CAPB : S_EXEC;
      S_CAPB:     state_nxt = S_EXEC;
      S_EXEC: begin
        priority if (status.is_cal) state_nxt = S_CAL2;
        else if (status.div_start) state_nxt = S_DIV;
        else                       state_nxt = S_DONE;
      end
      S_CAL2:     state_nxt = S_CAL3;
      S_CAL3:     state_nxt = S_DONE;
      S_DIV:      if (status.div_done) state_nxt = S_DIV_WB;
      S_DIV_WB:   state_nxt = S_DONE;
      S_DONE:     if (status.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    unique case (state_r)
      S_CLEAR:    cmd = CMD_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd      = in_valid ? CMD_LOAD : CMD_NONE;
      end
      S_PREP:     cmd = CMD_PREP;
      S_CHAIN_RD: cmd = status.chain_done ? CMD_NONE : CMD_CHAIN_RD;
      S_CHAIN_WB: cmd = CMD_CHAIN_WB;
      S_RD_A:     cmd = CMD_RD_A;
      S_RD_B:     cmd = CMD_RD_B;
      S_CAPB:     cmd = CMD_CAPB;
      S_EXEC:     cmd = CMD_EXEC;
      S_CAL2:     cmd = CMD_CAL2;
      S_CAL3:     cmd = CMD_CAL3;
      S_DIV:      cmd = CMD_NONE;
      S_DIV_WB:   cmd = CMD_DIV_WB;
      S_DONE:     cmd = status.out_free ? CMD_RESULT : CMD_NONE;
      default:    cmd = CMD_NONE;
    endcase
  end

  // An accepted item always starts with the preparation step.
  `PL0_ASSERT(a_accept_prep, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_PREP), "accept did not lead to prep")
  // A result is only loaded when the output register can take it.
  `PL0_ASSERT(a_result_free, clk, rst_n, (cmd == CMD_RESULT) |-> status.out_free, "result loaded into a busy output register")
  // The divider only finishes while the controller waits for it.
  `PL0_ASSERT(a_div_state, clk, rst_n, status.div_done |-> (state_r == S_DIV), "divider finished outside its wait state")
  // The clearing pass runs to the last entry before the block takes items.
  `PL0_ASSERT(a_clear_hold, clk, rst_n, (state_r == S_CLEAR && !status.clear_last) |=> (state_r == S_CLEAR), "clearing pass left early")

endmodule

// ===== sv/pl0_pcode_stack_machine.sv =====
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine
// Executes one PL/0 p-code instruction per input item and returns one result.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one instruction per
//   item; the result channel (out_valid/out_ready/out_data) returns one item
//   per instruction with the next pc, halt mark, print data and fault code.
//   One instruction is in flight at a time; in_ready is high only when idle.
//   Steps: LIT, INT, JMP and the newline operation go through prep and
//   execute; unary operations, write and JPC first read one stack word,
//   binary ones and return read two, and LOD, STO and CAL first walk the
//   static link hop by hop; a division waits for the iterative divider.
//   The single-port-read stack memory sets these steps; the next item can be
//   accepted once the result is loaded. After reset the stack is cleared one
//   word per cycle, all STACK_DEPTH words (512 by default), during which no
//   item is accepted; pointers and pc reset to top 0, base 1, pc 0.
//   A finished result sits in the output register while out_ready is low; the
//   block takes the next item and holds its result until the register frees.
// ----------------------------------------------------------------------------
module pl0_pcode_stack_machine #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LEVEL   = pl0_pkg::MAX_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pl0_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pl0_pkg::out_item_t out_data
);
  import pl0_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Instruction sequencer.
  pl0_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stack, pointers and arithmetic.
  pl0_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LEVEL   (MAX_LEVEL)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine testbench
// Drives instruction items with random gaps and stalls. A scoreboard class
// keeps its own stack, pointers and pc, predicts each result and compares
// every result item field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pl0_pkg::*;

  localparam int DEPTH = 512;
  localparam int HOPS_MAX = 31;

  // Scoreboard: a shadow copy of the machine and a queue of predicted results.
  class pcode_scoreboard;
    logic [31:0] stack_mem [DEPTH];
    int unsigned top_p, base_p, pc;
    int unsigned fault_now;
    out_item_t expected_q[$];
    int errors;
    int prints, returns, calls, div_zero, stack_faults;

    function void clear();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      top_p = 0;
      base_p = 1;
      pc = 0;
      errors = 0;
    endfunction

    function int unsigned clamp(longint v);
      if (v < 0) begin
        fault_now = FLT_STACK;
        return 0;
      end
      if (v > DEPTH - 1) begin
        fault_now = FLT_STACK;
        return DEPTH - 1;
      end
      return int'(v);
    endfunction

    function int unsigned walk_chain(int unsigned hops);
      int unsigned b;
      b = base_p;
      if (hops > HOPS_MAX) hops = HOPS_MAX;
      for (int k = 0; k < hops; k++) b = clamp(longint'($signed(stack_mem[b])));
      return b;
    endfunction

    // Note an accepted instruction and predict its result.
    function void note_instruction(in_item_t it);
      int unsigned t, p, addr, nb, link;
      logic [31:0] arg, r;
      longint sa, a, b;
      logic divz;
      out_item_t res;
      arg = it.operand;
      sa = longint'($signed(arg));
      p = (pc + 1) % CODE_DEPTH;
      t = top_p;
      divz = 0;
      fault_now = FLT_NONE;
      res = '0;
      case (opcode_t'(it.opcode))
        OP_LIT: begin
          t = clamp(longint'(t) + 1);
          stack_mem[t] = arg;
        end
        OP_OPR: begin
          if (arg == SUB_RET) begin
            returns++;
            t = clamp(longint'(base_p) - 1);
            base_p = clamp(longint'($signed(stack_mem[clamp(longint'(t) + 2)])));
            p = stack_mem[clamp(longint'(t) + 3)] % CODE_DEPTH;
          end else if (arg == SUB_NEG) begin
            stack_mem[t] = 32'd0 - stack_mem[t];
          end else if (arg == SUB_ODD) begin
            stack_mem[t] = stack_mem[t] & 32'd1;
          end else if (arg == SUB_WRITE) begin
            prints++;
            res.print_valid = 1'b1;
            res.print_value = stack_mem[t];
            t = clamp(longint'(t) - 1);
          end else if (arg == SUB_NL) begin
            res.print_newline = 1'b1;
          end else if ((arg >= SUB_ADD && arg <= SUB_DIV) ||
                       (arg >= SUB_EQ && arg <= SUB_LE)) begin
            t = clamp(longint'(t) - 1);
            a = longint'($signed(stack_mem[t]));
            b = longint'($signed(stack_mem[clamp(longint'(t) + 1)]));
            r = '0;
            case (arg)
              SUB_ADD: r = 32'(a + b);
              SUB_SUB: r = 32'(a - b);
              SUB_MUL: r = 32'(a * b);
              SUB_DIV: begin
                if (b == 0) divz = 1;
                else r = 32'(a / b);
              end
              SUB_EQ: r = {31'd0, a == b};
              SUB_NE: r = {31'd0, a != b};
              SUB_LT: r = {31'd0, a < b};
              SUB_GE: r = {31'd0, a >= b};
              SUB_GT: r = {31'd0, a > b};
              default: r = {31'd0, a <= b};
            endcase
            stack_mem[t] = r;
          end
        end
        OP_LOD: begin
          addr = clamp(longint'(walk_chain(it.level)) + sa);
          r = stack_mem[addr];
          t = clamp(longint'(t) + 1);
          stack_mem[t] = r;
        end
        OP_STO: begin
          addr = clamp(longint'(walk_chain(it.level)) + sa);
          stack_mem[addr] = stack_mem[t];
          t = clamp(longint'(t) - 1);
        end
        OP_CAL: begin
          calls++;
          link = walk_chain(it.level);
          nb = clamp(longint'(t) + 1);
          stack_mem[nb] = link;
          stack_mem[clamp(longint'(t) + 2)] = base_p;
          stack_mem[clamp(longint'(t) + 3)] = p;
          base_p = nb;
          p = arg % CODE_DEPTH;
        end
        OP_INT: t = clamp(longint'(t) + sa);
        OP_JMP: p = arg % CODE_DEPTH;
        default: begin
          if (stack_mem[t] == {27'd0, it.level}) p = arg % CODE_DEPTH;
          t = clamp(longint'(t) - 1);
        end
      endcase
      top_p = t;
      pc = p;
      if (divz && fault_now == FLT_NONE) fault_now = FLT_DIV_ZERO;
      if (divz) div_zero++;
      if (fault_now == FLT_STACK) stack_faults++;
      res.next_pc = p[7:0];
      res.halted = (p == 0);
      res.fault = fault_now[1:0];
      expected_q.push_back(res);
    endfunction

    // Compare a result item with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.next_pc !== exp_r.next_pc) begin
        $error("next_pc: expected %0d, actual %0d", exp_r.next_pc, got.next_pc);
        errors++;
      end
      if (got.halted !== exp_r.halted) begin
        $error("halted: expected %0d, actual %0d", exp_r.halted, got.halted);
        errors++;
      end
      if (got.print_valid !== exp_r.print_valid) begin
        $error("print_valid: expected %0d, actual %0d", exp_r.print_valid,
               got.print_valid);
        errors++;
      end
      if (got.print_value !== exp_r.print_value) begin
        $error("print_value: expected %0d, actual %0d", exp_r.print_value,
               got.print_value);
        errors++;
      end
      if (got.print_newline !== exp_r.print_newline) begin
        $error("print_newline: expected %0d, actual %0d", exp_r.print_newline,
               got.print_newline);
        errors++;
      end
      if (got.fault !== exp_r.fault) begin
        $error("fault: expected %0d, actual %0d", exp_r.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic sink_on;
  pcode_scoreboard sb;
  int sent;

  pl0_pcode_stack_machine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one instruction item and note it at acceptance. Valid drops only
  // when a gap follows, so back-to-back items never see it toggle.
  task automatic send_instr(opcode_t op, logic [4:0] lvl, logic [31:0] arg);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, level: lvl, operand: arg};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_instruction('{opcode: op, level: lvl, operand: arg});
    sent++;
  endtask

  // Result side: random stalls, checks at each accepted result.
  initial begin
    out_ready = 1'b0;
    wait (sink_on === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : (gap_len() == 0 || $urandom_range(0, 1));
    end
  end

  function automatic logic [31:0] rand_opr();
    logic [31:0] codes [14];
    codes = '{SUB_NEG, SUB_ADD, SUB_SUB, SUB_MUL, SUB_DIV, SUB_ODD, SUB_EQ,
              SUB_NE, SUB_LT, SUB_GE, SUB_GT, SUB_LE, SUB_WRITE, SUB_NL};
    if ($urandom_range(0, 19) == 0) return $urandom();
    if ($urandom_range(0, 24) == 0) return SUB_RET;
    return codes[$urandom_range(0, 13)];
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(0, 20) - 10;
    endcase
  endfunction

  // One procedure-like sequence: call, allocate, compute, store, load, write or conditional jump, return.
  task automatic well_formed_block();
    send_instr(OP_CAL, 5'($urandom_range(0, 2)), $urandom());
    send_instr(OP_INT, 5'd0, $urandom_range(3, 6));
    repeat ($urandom_range(1, 4)) begin
      send_instr(OP_LIT, 5'($urandom()), rand_word());
      send_instr(OP_LIT, 5'($urandom()), rand_word());
      send_instr(OP_OPR, 5'($urandom()), rand_opr());
      send_instr(OP_STO, 5'($urandom_range(0, 2)), $urandom_range(3, 5));
      send_instr(OP_LOD, 5'($urandom_range(0, 3)), $urandom_range(0, 5));
      if ($urandom_range(0, 1)) send_instr(OP_OPR, 5'd0, SUB_WRITE);
      else send_instr(OP_JPC, 5'($urandom_range(0, 1)), $urandom());
    end
    send_instr(OP_OPR, 5'd0, SUB_RET);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Main stimulus.
  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    sink_on = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    sink_on = 1'b1;

    // Directed: every opcode, several operations, field extremes, faults and wraps.
    send_instr(OP_LIT, 5'd31, 32'h7FFF_FFFF);
    send_instr(OP_LIT, 5'd0, 32'hFFFF_FFFF);
    send_instr(OP_OPR, 5'd0, SUB_ADD);
    send_instr(OP_LIT, 5'd0, 32'h8000_0000);
    send_instr(OP_LIT, 5'd0, 32'hFFFF_FFFF);
    send_instr(OP_OPR, 5'd0, SUB_DIV);
    send_instr(OP_LIT, 5'd0, 32'd0);
    send_instr(OP_OPR, 5'd0, SUB_DIV);
    send_instr(OP_OPR, 5'd0, SUB_NEG);
    send_instr(OP_OPR, 5'd0, SUB_ODD);
    send_instr(OP_OPR, 5'd0, SUB_WRITE);
    send_instr(OP_OPR, 5'd0, SUB_NL);
    send_instr(OP_OPR, 5'd0, 32'd7);
    send_instr(OP_INT, 5'd0, 32'h8000_0000);
    send_instr(OP_OPR, 5'd0, SUB_DIV);
    send_instr(OP_INT, 5'd0, 32'h7FFF_FFFF);
    send_instr(OP_LOD, 5'd31, 32'h8000_0000);
    send_instr(OP_STO, 5'd31, 32'h7FFF_FFFF);
    send_instr(OP_INT, 5'd0, -32'sd600);
    send_instr(OP_CAL, 5'd31, 32'hFFFF_FF00);
    send_instr(OP_JMP, 5'd0, 32'hFFFF_FFFF);
    send_instr(OP_JPC, 5'd1, 32'h0000_0100);
    send_instr(OP_OPR, 5'd0, SUB_RET);
    send_instr(OP_JMP, 5'd0, 32'd0);

    // Hold off until every result is back.
    drain();
    send_instr(OP_INT, 5'd0, 32'd8);

    // Random: mostly well-formed call blocks, some raw noise.
    while (sent < 1400) begin
      if ($urandom_range(0, 9) < 7) well_formed_block();
      else repeat ($urandom_range(1, 6))
        send_instr(opcode_t'($urandom_range(0, 7)), 5'($urandom()),
                   ($urandom_range(0, 1)) ? rand_word() :
                   (($urandom_range(0, 1)) ? rand_opr() : $urandom()));
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Ran %0d instructions: %0d writes, %0d calls, %0d returns,", sent,
             sb.prints, sb.calls, sb.returns);
    $display("%0d divisions by zero and %0d stack range faults predicted.",
             sb.div_zero, sb.stack_faults);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
